// ----- src/rtch_pkg.sv -----
// ----------------------------------------------------------------------------
// rtch_pkg
// Shared types and constants for the ray/triangle closest-hit engine.
// ----------------------------------------------------------------------------
package rtch_pkg;

  localparam int unsigned QW        = 32;
  localparam int unsigned FACE_W    = 16;
  localparam logic signed [QW-1:0] EPS_Q = 32'sd7;
  localparam logic signed [QW-1:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [QW-1:0] S32_MIN = 32'sh8000_0000;
  localparam logic [16:0] MAX_FACES = 17'd65536;

  localparam logic [2:0] REG_ORG_X = 3'd0;
  localparam logic [2:0] REG_ORG_Y = 3'd1;
  localparam logic [2:0] REG_ORG_Z = 3'd2;
  localparam logic [2:0] REG_DIR_X = 3'd3;
  localparam logic [2:0] REG_DIR_Y = 3'd4;
  localparam logic [2:0] REG_DIR_Z = 3'd5;
  localparam logic [2:0] REG_MODE  = 3'd6;

  typedef logic signed [QW-1:0] q_t;

  // start/operands/results of the shared divider
  typedef struct packed {
    logic        start;
    logic signed [QW-1:0] num;
    logic signed [QW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic signed [QW-1:0] quo;
  } div_rsp_t;

  function automatic q_t sat32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) return S32_MAX;
    if (x < -66'sd2147483648) return S32_MIN;
    return x[QW-1:0];
  endfunction

endpackage

// ----- src/rtch_div.sv -----
// ----------------------------------------------------------------------------
// rtch_div
// Radix-2 restoring divider: sat32((num * 65536) / den), den > 0,
// truncated toward zero. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module rtch_div (
  input  logic               clk,
  input  logic               rst_n,
  input  rtch_pkg::div_req_t req,
  output rtch_pkg::div_rsp_t rsp
);

  logic [47:0] dvd_r, dvd_nxt;
  logic [31:0] den_r, den_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        neg_r, neg_nxt;
  logic        done_r, done_nxt;
  logic [47:0] quo_r, quo_nxt;
  logic [32:0] trial;
  logic [33:0] shifted;
  logic signed [65:0] sq;
  logic [31:0] anum;

  assign anum = req.num[31] ? (~req.num + 32'd1) : req.num;

  always_comb begin
    dvd_nxt  = dvd_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    neg_nxt  = neg_r;
    quo_nxt  = quo_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, dvd_r[47]};
    trial    = shifted[32:0] - {1'b0, den_r};
    if (req.start) begin
      dvd_nxt  = {anum, 16'd0};
      den_nxt  = req.den;
      rem_nxt  = '0;
      cnt_nxt  = 6'd48;
      busy_nxt = 1'b1;
      neg_nxt  = req.num[31];
      quo_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[46:0], 1'b0};
      if (shifted[32:0] >= {1'b0, den_r}) begin
        rem_nxt = trial;
        quo_nxt = {quo_r[46:0], 1'b1};
      end else begin
        rem_nxt = shifted[32:0];
        quo_nxt = {quo_r[46:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
    quo_r <= quo_nxt;
  end

  always_comb begin
    sq = neg_r ? -$signed({18'd0, quo_r}) : $signed({18'd0, quo_r});
    rsp.done = done_r;
    rsp.quo  = rtch_pkg::sat32(sq);
  end

endmodule

// ----- src/rtch_mac.sv -----
// ----------------------------------------------------------------------------
// rtch_mac
// Shared 32x32 multiplier with floor shift and a wide accumulator.
// ----------------------------------------------------------------------------
module rtch_mac (
  input  logic              clk,
  input  logic              clear,
  input  logic              en,
  input  logic              sub,
  input  rtch_pkg::q_t      a,
  input  rtch_pkg::q_t      b,
  output logic signed [65:0] acc
);

  logic signed [63:0] prod_r;
  logic               vld_r, sub_r;
  logic signed [65:0] acc_r, acc_nxt;
  logic signed [65:0] term;

  always_comb begin
    term    = {{18{prod_r[63]}}, prod_r[63:16]};
    acc_nxt = acc_r;
    if (vld_r) acc_nxt = sub_r ? acc_r - term : acc_r + term;
    if (clear) acc_nxt = '0;
  end

  always_ff @(posedge clk) begin
    prod_r <= a * b;
    vld_r  <= en;
    sub_r  <= sub;
    acc_r  <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

// ----- src/ray_triangle_closest_hit_top.sv -----
// ----------------------------------------------------------------------------
// ray_triangle_closest_hit_top
// Moller-Trumbore ray/triangle test, nearest- or any-hit tracking, Q16.16.
// ----------------------------------------------------------------------------
// channel | dir | handshake          | payload
// in_     | in  | tvalid/tready      | tdata 9 vertex coords + face, tlast
// out_    | out | tvalid/tready      | tdata hit/dist/u/v/nearest..., tlast
// cfg_    | in  | wr_en, no wait     | index 0..6, 32-bit data
//
// One triangle: the edges first, then 24 products on the shared multiplier
// (two cross products and four dot products, with a step to flip the
// determinant), then three passes through the shared divider (48 quotient
// bits each). A miss skips the rest of the chain and finishes early.
// in_tready is high only while the sequencer is idle; the result word sits in
// an output register, so the next triangle is taken while it waits. The
// sequencer holds in its last state while the previous word is still unread.
// Synchronous active-low reset clears the ray registers to their defaults and
// the nearest-hit state.
module ray_triangle_closest_hit_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // vert0_x, vert0_y, vert0_z, vert1_x..z, vert2_x..z (32 each), face_number
  input  logic [303:0]  in_tdata,
  input  logic          in_tlast,   // last_face
  output logic          out_tvalid,
  input  logic          out_tready,
  // tri_hit, hit_distance, bary_u, bary_v, became_nearest, found_any,
  // nearest_distance, nearest_face, pad
  output logic [151:0]  out_tdata,
  output logic          out_tlast,  // is_last
  input  logic          cfg_wr_en,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0, S_EDGE = 4'd1, S_P = 4'd2,
    S_DET = 4'd3, S_TV = 4'd4, S_U = 4'd5, S_Q = 4'd6, S_V = 4'd7,
    S_T = 4'd8, S_DIVT = 4'd9, S_DIVU = 4'd10, S_DIVV = 4'd11, S_FIN = 4'd12,
    S_OUT = 4'd13;

  rtch_pkg::q_t org_r [3];
  rtch_pkg::q_t dir_r [3];
  logic         mode_r;
  rtch_pkg::q_t v0_r [3], e1_r [3], e2_r [3], tv_r [3], p_r [3], q_r [3];
  rtch_pkg::q_t det_r, u_r, v_r, t_r, tq_r, uq_r;
  logic [15:0]  face_r;
  logic         last_r;

  logic [3:0] st_r, st_nxt;
  logic [2:0] stp_r;  // step in a phase
  logic [2:0] cmp_r;  // component being produced

  rtch_pkg::q_t best_r;
  logic [15:0]  bface_r;
  logic         seen_r;

  logic [151:0] otd_r;
  logic         ovld_r, olast_r;
  logic         out_free;   // output register can take a new word this cycle

  // mac
  logic mac_clr, mac_en, mac_sub;
  rtch_pkg::q_t mac_a, mac_b;
  logic signed [65:0] acc;
  rtch_pkg::div_req_t dreq;
  rtch_pkg::div_rsp_t drsp;

  rtch_mac u_mac (.clk(clk), .clear(mac_clr), .en(mac_en), .sub(mac_sub),
                  .a(mac_a), .b(mac_b), .acc(acc));
  rtch_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = ovld_r;
  assign out_tdata  = otd_r;
  assign out_tlast  = olast_r;
  assign out_free   = !ovld_r || out_tready;

  // index helpers for cross products: component c uses (c+1,c+2)-(c+2,c+1)
  function automatic logic [1:0] nx(input logic [2:0] c, input logic [1:0] k);
    logic [2:0] s;
    s = c + {1'b0, k};
    if (s >= 3'd3) s = s - 3'd3;
    return s[1:0];
  endfunction

  // operand select; stp 0,1 (cross) or 0..2 (dot) issue, then drain, 4 read
  always_comb begin
    logic [1:0] i1, i2, ci;
    i1 = nx(cmp_r, 2'd1);
    i2 = nx(cmp_r, 2'd2);
    ci = cmp_r[1:0];
    mac_en  = 1'b0;
    mac_sub = 1'b0;
    mac_a   = '0;
    mac_b   = '0;
    mac_clr = 1'b0;
    unique case (st_r)
      S_P, S_Q: begin
        mac_en  = (stp_r < 3'd2);
        mac_sub = (stp_r == 3'd1);
        mac_clr = (stp_r == 3'd4);
        if (st_r == S_P) begin
          mac_a = (stp_r == 3'd0) ? dir_r[i1] : dir_r[i2];
          mac_b = (stp_r == 3'd0) ? e2_r[i2] : e2_r[i1];
        end else begin
          mac_a = (stp_r == 3'd0) ? tv_r[i1] : tv_r[i2];
          mac_b = (stp_r == 3'd0) ? e1_r[i2] : e1_r[i1];
        end
      end
      S_DET, S_U, S_V, S_T: begin
        mac_en  = (stp_r < 3'd3);
        mac_clr = (stp_r == 3'd4);
        unique case (st_r)
          S_DET:   begin mac_a = e1_r[stp_r[1:0]]; mac_b = p_r[stp_r[1:0]]; end
          S_U:     begin mac_a = tv_r[stp_r[1:0]]; mac_b = p_r[stp_r[1:0]]; end
          S_V:     begin mac_a = dir_r[stp_r[1:0]]; mac_b = q_r[stp_r[1:0]]; end
          default: begin mac_a = e2_r[stp_r[1:0]]; mac_b = q_r[stp_r[1:0]]; end
        endcase
        if (stp_r == 3'd3) begin
          mac_a = '0;
          mac_b = '0;
        end
      end
      default: mac_clr = 1'b1;
    endcase
    if (ci == 2'd3) mac_clr = 1'b1;
  end

  logic signed [65:0] accw;
  rtch_pkg::q_t accs;
  assign accw = acc;
  assign accs = rtch_pkg::sat32(accw);

  logic signed [65:0] uv_sum;
  assign uv_sum = $signed({{34{u_r[31]}}, u_r}) + $signed({{34{accs[31]}}, accs});

  always_ff @(posedge clk) begin
    logic signed [65:0] d;
    logic qual, nearer;
    logic [151:0] od;
    logic go, ov;
    if (!rst_n) begin
      org_r[0] <= '0; org_r[1] <= '0; org_r[2] <= '0;
      dir_r[0] <= '0; dir_r[1] <= '0; dir_r[2] <= 32'sd65536;
      mode_r <= 1'b0;
      st_r <= S_IDLE; stp_r <= '0; cmp_r <= '0;
      best_r <= rtch_pkg::S32_MAX; bface_r <= '0; seen_r <= 1'b0;
      ovld_r <= 1'b0;
      dreq.start <= 1'b0;
    end else begin
      go = 1'b0;
      ov = ovld_r && !out_tready;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          rtch_pkg::REG_ORG_X: org_r[0] <= cfg_data;
          rtch_pkg::REG_ORG_Y: org_r[1] <= cfg_data;
          rtch_pkg::REG_ORG_Z: org_r[2] <= cfg_data;
          rtch_pkg::REG_DIR_X: dir_r[0] <= cfg_data;
          rtch_pkg::REG_DIR_Y: dir_r[1] <= cfg_data;
          rtch_pkg::REG_DIR_Z: dir_r[2] <= cfg_data;
          rtch_pkg::REG_MODE:  mode_r   <= cfg_data[0];
          default: ;
        endcase
      end
      unique case (st_r)
        S_IDLE: if (in_tvalid && in_tready) begin
          for (int i = 0; i < 3; i++) begin
            v0_r[i] <= in_tdata[32*i +: 32];
            e1_r[i] <= in_tdata[32*(3+i) +: 32];
            e2_r[i] <= in_tdata[32*(6+i) +: 32];
          end
          face_r <= in_tdata[303:288];
          last_r <= in_tlast;
          st_r <= S_EDGE; stp_r <= '0; cmp_r <= '0;
        end
        S_EDGE: begin
          for (int i = 0; i < 3; i++) begin
            e1_r[i] <= rtch_pkg::sat32(66'(e1_r[i]) - 66'(v0_r[i]));
            e2_r[i] <= rtch_pkg::sat32(66'(e2_r[i]) - 66'(v0_r[i]));
          end
          st_r <= S_P;
        end
        S_P, S_Q: begin
          if (stp_r == 3'd4) begin
            if (st_r == S_P) p_r[cmp_r[1:0]] <= accs;
            else q_r[cmp_r[1:0]] <= accs;
            stp_r <= '0;
            if (cmp_r == 3'd2) begin
              cmp_r <= '0;
              st_r <= (st_r == S_P) ? S_DET : S_V;
            end else cmp_r <= cmp_r + 3'd1;
          end else stp_r <= stp_r + 3'd1;
        end
        S_DET, S_U, S_V, S_T: begin
          if (stp_r == 3'd4) begin
            stp_r <= '0;
            unique case (st_r)
              S_DET: begin det_r <= accs; st_r <= S_TV; end
              S_U: begin
                u_r <= accs;
                st_r <= (accs >= 0 && accs <= det_r) ? S_Q : S_FIN;
                if (!(accs >= 0 && accs <= det_r)) t_r <= '0;
              end
              S_V: begin
                v_r <= accs;
                if (!accs[31] && uv_sum <= 66'(det_r)) st_r <= S_T;
                else begin st_r <= S_FIN; t_r <= '0; end
              end
              default: begin
                dreq.num <= accs; dreq.den <= det_r; go = 1'b1;
                st_r <= S_DIVT;
              end
            endcase
          end else stp_r <= stp_r + 3'd1;
        end
        S_TV: begin
          d = -66'(det_r);
          for (int i = 0; i < 3; i++)
            tv_r[i] <= (det_r > 0) ? rtch_pkg::sat32(66'(org_r[i]) - 66'(v0_r[i]))
                                   : rtch_pkg::sat32(66'(v0_r[i]) - 66'(org_r[i]));
          if (det_r > 0) begin
            st_r <= (det_r >= rtch_pkg::EPS_Q) ? S_U : S_FIN;
          end else begin
            det_r <= rtch_pkg::sat32(d);
            st_r <= (rtch_pkg::sat32(d) >= rtch_pkg::EPS_Q) ? S_U : S_FIN;
          end
          t_r <= '0;
        end
        S_DIVT: if (drsp.done) begin
          tq_r <= drsp.quo;
          dreq.num <= u_r; dreq.den <= det_r; go = 1'b1;
          st_r <= S_DIVU;
        end
        S_DIVU: if (drsp.done) begin
          uq_r <= drsp.quo;
          dreq.num <= v_r; dreq.den <= det_r; go = 1'b1;
          st_r <= S_DIVV;
        end
        S_DIVV: if (drsp.done) begin
          v_r <= drsp.quo; u_r <= uq_r; t_r <= tq_r;
          st_r <= S_OUT;
        end
        S_FIN: if (out_free) begin
          // miss: only the tracked state is shown
          od = '0;
          od[98] = seen_r;
          od[130:99] = best_r;
          od[146:131] = bface_r;
          otd_r <= od; olast_r <= last_r; ov = 1'b1;
          if (last_r) begin
            best_r <= rtch_pkg::S32_MAX; bface_r <= '0; seen_r <= 1'b0;
          end
          st_r <= S_IDLE;
        end
        S_OUT: if (out_free) begin
          qual = (t_r >= rtch_pkg::EPS_Q);
          nearer = qual && !mode_r && (t_r < best_r) &&
                   ({1'b0, face_r} < rtch_pkg::MAX_FACES);
          od = '0;
          od[0] = 1'b1;
          od[32:1] = t_r;
          od[64:33] = u_r;
          od[96:65] = v_r;
          od[97] = nearer;
          od[98] = seen_r | (qual && mode_r) | nearer;
          od[130:99] = nearer ? t_r : best_r;
          od[146:131] = nearer ? face_r : bface_r;
          otd_r <= od; olast_r <= last_r; ov = 1'b1;
          if (last_r) begin
            best_r <= rtch_pkg::S32_MAX; bface_r <= '0; seen_r <= 1'b0;
          end else begin
            seen_r <= od[98];
            if (nearer) begin best_r <= t_r; bface_r <= face_r; end
          end
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
      dreq.start <= go;
      ovld_r <= ov;
    end
  end

endmodule

// ----- tb/ray_triangle_closest_hit_top_tb.sv -----
// ----------------------------------------------------------------------------
// ray_triangle_closest_hit_top_tb
// Self-checking bench for the ray/triangle closest-hit engine: triangles are
// streamed against several ray settings, and each result word is compared
// with an in-bench Q16.16 Moller-Trumbore predictor, including the nearest-hit
// tracking and the any-hit mode.
// ----------------------------------------------------------------------------
module ray_triangle_closest_hit_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE       = 65536;
  localparam int     GAP_MAX   = 12;
  localparam int     DRAIN     = 250;       // a bit over one triangle's latency
  localparam int     CYCLE_CAP = 1_000_000;

  typedef longint vec3_t [3];

  // one triangle word as sent
  typedef struct {
    logic [287:0] coords;   // vert0_x at the bottom, vert2_z at the top
    logic [15:0]  face;
    bit           last;
  } tri_t;

  // one result word as expected
  typedef struct {
    bit          hit;
    logic [31:0] hit_dist;
    logic [31:0] u;
    logic [31:0] v;
    bit          nearer;
    bit          found;
    logic [31:0] near_dist;
    logic [15:0] near_face;
    bit          last;
  } hit_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [303:0] in_tdata = '0;   // vert0_x..vert2_z (32 each), face_number
  logic         in_tlast = 1'b0; // last_face
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [151:0] out_tdata;       // tri_hit, hit_distance, bary_u, bary_v,
                                 // became_nearest, found_any, nearest_distance,
                                 // nearest_face, pad
  logic         out_tlast;       // is_last
  logic         cfg_wr_en = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  ray_triangle_closest_hit_top dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: its own copy of the ray registers and the nearest-hit state
  // ---------------------------------------------------------------------------
  longint ray_org [3];
  longint ray_dir [3];
  bit     any_mode;
  longint near_dist;
  logic [15:0] near_face;
  bit     seen_hit;

  tri_t        pending_tris [$];
  hit_result_t expected_hits [$];

  int errors, words_in, words_out, hits_seen, nearer_seen, meshes_closed;
  int cycles;
  bit burst_mode;   // no random sender/receiver gaps while set (hold-off stays)

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // exact product, then floor back to Q16.16
  function automatic longint fx_mul(longint a, longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic vec3_t fx_cross(vec3_t a, vec3_t b);
    vec3_t r;
    r[0] = clamp32(fx_mul(a[1], b[2]) - fx_mul(a[2], b[1]));
    r[1] = clamp32(fx_mul(a[2], b[0]) - fx_mul(a[0], b[2]));
    r[2] = clamp32(fx_mul(a[0], b[1]) - fx_mul(a[1], b[0]));
    return r;
  endfunction

  function automatic longint fx_dot(vec3_t a, vec3_t b);
    return clamp32(fx_mul(a[0], b[0]) + fx_mul(a[1], b[1]) + fx_mul(a[2], b[2]));
  endfunction

  function automatic longint fx_div(longint x, longint det);
    return clamp32((x * ONE) / det);
  endfunction

  function automatic longint coord(tri_t tr, int k);
    return longint'(signed'(tr.coords[32*k +: 32]));
  endfunction

  function automatic hit_result_t predict_hit(tri_t tr);
    hit_result_t r;
    vec3_t v0, e1, e2, tv, p, q;
    longint det, u, v, t;
    bit hit;
    u = 0; v = 0; t = 0; hit = 0;
    r.nearer = 0;
    for (int i = 0; i < 3; i++) begin
      v0[i] = coord(tr, i);
      e1[i] = clamp32(coord(tr, 3 + i) - v0[i]);
      e2[i] = clamp32(coord(tr, 6 + i) - v0[i]);
    end
    p = fx_cross(ray_dir, e2);
    det = fx_dot(e1, p);
    // flip so the determinant is positive (back faces count too)
    if (det > 0) begin
      for (int i = 0; i < 3; i++) tv[i] = clamp32(ray_org[i] - v0[i]);
    end else begin
      for (int i = 0; i < 3; i++) tv[i] = clamp32(v0[i] - ray_org[i]);
      det = clamp32(-det);
    end
    if (det >= 7) begin
      u = fx_dot(tv, p);
      if (u >= 0 && u <= det) begin
        q = fx_cross(tv, e1);
        v = fx_dot(ray_dir, q);
        if (v >= 0 && u + v <= det) begin
          t = fx_div(fx_dot(e2, q), det);
          u = fx_div(u, det);
          v = fx_div(v, det);
          hit = 1;
        end
      end
    end
    if (!hit) begin
      t = 0; u = 0; v = 0;
    end
    // ties keep the old face; every 16-bit face is below the face limit
    if (hit && t >= 7) begin
      if (any_mode) begin
        seen_hit = 1;
      end else if (t < near_dist) begin
        seen_hit  = 1;
        near_dist = t;
        near_face = tr.face;
        r.nearer  = 1;
      end
    end
    r.hit = hit;
    r.hit_dist = t[31:0];
    r.u = u[31:0];
    r.v = v[31:0];
    r.found = seen_hit;
    r.near_dist = near_dist[31:0];
    r.near_face = near_face;
    r.last = tr.last;
    if (tr.last) begin
      near_dist = 64'sd2147483647;
      near_face = '0;
      seen_hit  = 0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  bit in_taken;
  int in_gap_left, in_gap_next;

  always @(posedge clk) begin
    in_taken = rst_n && in_tvalid && in_tready;
    if (in_taken) begin
      tri_t tr;
      tr.coords = in_tdata[287:0];
      tr.face   = in_tdata[303:288];
      tr.last   = in_tlast;
      expected_hits.insert(expected_hits.size(), predict_hit(tr));
      words_in++;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      // word still on offer
    end else if (in_taken && in_gap_next > 0) begin
      in_tvalid   <= 1'b0;
      in_gap_left <= in_gap_next - 1;
      in_gap_next <= 0;
    end else if (in_gap_left > 0) begin
      in_tvalid   <= 1'b0;
      in_gap_left <= in_gap_left - 1;
    end else if (pending_tris.size() > 0) begin
      tri_t tr;
      tr = pending_tris.pop_front();
      in_tdata    <= {tr.face, tr.coords};
      in_tlast    <= tr.last;
      in_tvalid   <= 1'b1;
      in_gap_next <= burst_mode ? 0 : $urandom_range(0, GAP_MAX);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls plus one long hold-off so the engine backs up
  // ---------------------------------------------------------------------------
  bit out_taken;
  int out_wait_left;
  int hold_left;
  bit hold_done;

  always @(posedge clk) begin
    if (!hold_done && words_in == 150) begin
      hold_left <= 800;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n || hold_left > 0) begin
      out_tready <= 1'b0;
    end else if (out_taken && !burst_mode) begin
      out_wait_left = $urandom_range(0, GAP_MAX);
      out_tready <= (out_wait_left == 0);
    end else if (out_wait_left > 0) begin
      out_wait_left--;
      out_tready <= (out_wait_left == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("ERROR word %0d: %s got 0x%08h expected 0x%08h", words_out, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    out_taken = rst_n && out_tvalid && out_tready;
    if (out_taken) begin
      hit_result_t w;
      if (expected_hits.size() == 0) begin
        report("unexpected result word, tri_hit", out_tdata[0], 0);
      end else begin
        w = expected_hits.pop_front();
        if (out_tdata[0] !== w.hit)             report("tri_hit", out_tdata[0], w.hit);
        if (out_tdata[32:1] !== w.hit_dist)
          report("hit_distance", out_tdata[32:1], w.hit_dist);
        if (out_tdata[64:33] !== w.u)           report("bary_u", out_tdata[64:33], w.u);
        if (out_tdata[96:65] !== w.v)           report("bary_v", out_tdata[96:65], w.v);
        if (out_tdata[97] !== w.nearer)         report("became_nearest", out_tdata[97], w.nearer);
        if (out_tdata[98] !== w.found)          report("found_any", out_tdata[98], w.found);
        if (out_tdata[130:99] !== w.near_dist)
          report("nearest_distance", out_tdata[130:99], w.near_dist);
        if (out_tdata[146:131] !== w.near_face)
          report("nearest_face", out_tdata[146:131], w.near_face);
        if (out_tlast !== w.last)               report("is_last", out_tlast, w.last);
        hits_seen     += w.hit;
        nearer_seen   += w.nearer;
        meshes_closed += w.last;
      end
      words_out++;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles,
               expected_hits.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] rnd32();
    return $urandom();
  endfunction

  function automatic longint rnd_q(int lim);
    return longint'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  // coordinates given in Q16.16
  task automatic add_tri(longint c [9], logic [15:0] face, bit last);
    tri_t tr;
    for (int k = 0; k < 9; k++) tr.coords[32*k +: 32] = 32'(clamp32(c[k]));
    tr.face = face;
    tr.last = last;
    pending_tris.insert(pending_tris.size(), tr);
  endtask

  // triangle placed around a point on the ray, so hits are common
  task automatic add_ray_tri(bit last);
    longint c [9];
    longint t0, size;
    t0 = rnd_q(12 * ONE) + 6 * ONE;
    size = ($urandom_range(0, 3) == 0) ? 64 * ONE : 3 * ONE;
    for (int k = 0; k < 9; k++)
      c[k] = ray_org[k % 3] + fx_mul(ray_dir[k % 3], t0) + rnd_q(int'(size));
    add_tri(c, 16'($urandom()), last);
  endtask

  task automatic add_noise_tri(bit last);
    longint c [9];
    for (int k = 0; k < 9; k++) c[k] = longint'(signed'(rnd32()));
    add_tri(c, 16'($urandom()), last);
  endtask

  task automatic wait_idle();
    while (pending_tris.size() > 0 || in_tvalid || expected_hits.size() > 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // writes the register and the predictor's copy while the engine is idle
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      rtch_pkg::REG_ORG_X, rtch_pkg::REG_ORG_Y, rtch_pkg::REG_ORG_Z:
        ray_org[idx] = longint'(signed'(val));
      rtch_pkg::REG_DIR_X, rtch_pkg::REG_DIR_Y, rtch_pkg::REG_DIR_Z:
        ray_dir[idx - 3] = longint'(signed'(val));
      rtch_pkg::REG_MODE: any_mode = val[0];
      default: ;   // unused index, ignored
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_ray(longint ox, oy, oz, dx, dy, dz, bit mode);
    write_reg(rtch_pkg::REG_ORG_X, ox[31:0]);
    write_reg(rtch_pkg::REG_ORG_Y, oy[31:0]);
    write_reg(rtch_pkg::REG_ORG_Z, oz[31:0]);
    write_reg(rtch_pkg::REG_DIR_X, dx[31:0]);
    write_reg(rtch_pkg::REG_DIR_Y, dy[31:0]);
    write_reg(rtch_pkg::REG_DIR_Z, dz[31:0]);
    write_reg(rtch_pkg::REG_MODE, {31'b0, mode});
  endtask

  task automatic random_phase(int n, int noise_pct);
    for (int i = 0; i < n; i++) begin
      bit last;
      last = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 99) < noise_pct) add_noise_tri(last);
      else add_ray_tri(last);
    end
    add_ray_tri(1'b1);
  endtask

  initial begin
    longint c [9];
    for (int i = 0; i < 3; i++) begin
      ray_org[i] = 0;
      ray_dir[i] = 0;
    end
    ray_dir[2] = ONE;
    any_mode   = 0;
    near_dist  = 64'sd2147483647;
    near_face  = '0;
    seen_hit   = 0;
    burst_mode = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset ray: origin 0, direction +z
    c = '{-ONE, -ONE, 5*ONE,  ONE, -ONE, 5*ONE,  0, ONE, 5*ONE};
    add_tri(c, 16'd10, 1'b0);                 // plain hit at t=5
    add_tri(c, 16'd11, 1'b0);                 // same distance: tie keeps face 10
    c = '{-ONE, -ONE, 2*ONE,  0, ONE, 2*ONE,  ONE, -ONE, 2*ONE};
    add_tri(c, 16'hFFFF, 1'b0);               // nearer, opposite winding
    c = '{-ONE, -ONE, -3*ONE,  ONE, -ONE, -3*ONE,  0, ONE, -3*ONE};
    add_tri(c, 16'd3, 1'b0);                  // behind origin: hit, not counted
    c = '{0, 0, 0,  ONE, 0, 0,  0, ONE, 0};
    add_tri(c, 16'd4, 1'b0);                  // t of zero, below epsilon
    c = '{0, 0, ONE,  ONE, 0, ONE,  0, ONE, ONE};
    add_tri(c, 16'd5, 1'b0);                  // ray through a vertex, u = v = 0
    c = '{2*ONE, 2*ONE, 4*ONE,  3*ONE, 2*ONE, 4*ONE,  2*ONE, 3*ONE, 4*ONE};
    add_tri(c, 16'd6, 1'b0);                  // off to the side: miss
    c = '{0, 0, 0,  ONE, 0, 5*ONE,  2*ONE, 0, 9*ONE};
    add_tri(c, 16'd7, 1'b0);                  // plane holds the ray: det 0
    c = '{0, 0, ONE,  1, 0, ONE,  0, 1, ONE};
    add_tri(c, 16'd8, 1'b0);                  // tiny triangle, det under epsilon
    for (int k = 0; k < 9; k++) c[k] = (k % 2) ? -64'sd2147483648 : 64'sd2147483647;
    add_tri(c, 16'd9, 1'b0);                  // saturating differences
    for (int k = 0; k < 9; k++) c[k] = 64'sd2147483647;
    add_tri(c, 16'd0, 1'b0);
    for (int k = 0; k < 9; k++) c[k] = -64'sd2147483648;
    add_tri(c, 16'hFFFF, 1'b1);               // closes the mesh
    c = '{-ONE, -ONE, 7*ONE,  ONE, -ONE, 7*ONE,  0, ONE, 7*ONE};
    add_tri(c, 16'd12, 1'b1);                 // single-face mesh
    wait_idle();

    // closest hit, random small rays
    for (int ph = 0; ph < 2; ph++) begin
      set_ray(rnd_q(8*ONE), rnd_q(8*ONE), rnd_q(8*ONE),
              rnd_q(2*ONE), rnd_q(2*ONE), rnd_q(2*ONE), 1'b0);
      burst_mode = (ph == 1);
      random_phase(130, 15);
      wait_idle();
    end
    burst_mode = 0;

    // any-hit mode, then an unused register index
    set_ray(rnd_q(4*ONE), rnd_q(4*ONE), rnd_q(4*ONE), 0, ONE, -ONE, 1'b1);
    write_reg(3'd7, rnd32());
    c = '{-ONE, 5*ONE, -6*ONE,  ONE, 5*ONE, -6*ONE,  0, 7*ONE, -6*ONE};
    add_tri(c, 16'd1, 1'b0);
    random_phase(120, 15);
    wait_idle();

    // extreme ray registers
    set_ray(64'sd2147483647, -64'sd2147483648, 64'sd2147483647,
            -64'sd2147483648, 64'sd2147483647, -64'sd2147483648, 1'b0);
    random_phase(60, 60);
    wait_idle();
    set_ray(0, 0, 0, 64'sd2147483647, 1, -1, 1'b0);
    random_phase(40, 30);
    wait_idle();

    // tiny direction, then a fresh random closest-hit ray
    set_ray(rnd_q(ONE), rnd_q(ONE), rnd_q(ONE), 3, -2, 1, 1'b0);
    random_phase(40, 20);
    wait_idle();
    set_ray(rnd_q(100*ONE), rnd_q(100*ONE), rnd_q(100*ONE),
            rnd_q(4*ONE), rnd_q(4*ONE), rnd_q(4*ONE), 1'b0);
    random_phase(160, 10);
    wait_idle();

    $display("run covered %0d triangles against 8 ray settings: %0d hits, %0d new nearest,",
             words_in, hits_seen, nearer_seen);
    $display("%0d meshes closed, one long output hold-off, %0d errors", meshes_closed, errors);
    if (errors == 0 && expected_hits.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- ray_triangle_closest_hit_top.f -----
src/rtch_pkg.sv
src/rtch_div.sv
src/rtch_mac.sv
src/ray_triangle_closest_hit_top.sv
tb/ray_triangle_closest_hit_top_tb.sv
